// File: hdl/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types and constants for the sorted sequence merger.
// ----------------------------------------------------------------------------
package ssm_pkg;

  // Default number of entries in each sequence buffer
  localparam int unsigned LIST_DEPTH_DEF = 16;

  // Width of a stored value
  localparam int unsigned VALUE_W = 32;

  // Request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_PUSH_FIRST  = 2'd0,
    REQ_PUSH_SECOND = 2'd1,
    REQ_MERGE       = 2'd2
  } req_e;

  // Controller states
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_MERGE = 1'b1
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic in_ready;    // input channel may accept an item
    logic push_en;     // accepted item is a push request
    logic merge_step;  // load the next merged result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic slot_free;   // output register can take a result this cycle
    logic merge_last;  // the pending result is the final one of the merge
  } dp_status_t;

endpackage

// File: hdl/ssm_if.sv
// ----------------------------------------------------------------------------
// ssm_if
// Valid/ready channels for requests into and results out of the merger.
// ----------------------------------------------------------------------------
interface ssm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] value_in;

  modport source (output valid, output req_type, output value_in, input ready);
  modport sink   (input valid, input req_type, input value_in, output ready);
endinterface

interface ssm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] merged_value;
  logic               from_second;
  logic               last_value;
  logic               merge_empty;
  logic               push_dropped;

  modport source (output valid, output merged_value, output from_second,
                  output last_value, output merge_empty, output push_dropped,
                  input ready);
  modport sink   (input valid, input merged_value, input from_second,
                  input last_value, input merge_empty, input push_dropped,
                  output ready);
endinterface

// File: hdl/ssm_ctrl.sv
// ----------------------------------------------------------------------------
// ssm_ctrl
// Controller: accepts requests when idle and steps the merge one result at a
// time while the output register has room.
// ----------------------------------------------------------------------------
module ssm_ctrl
  import ssm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] req_type_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  req_e   req;

  assign req = req_e'(req_type_i);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (req == REQ_MERGE)) begin
          state_d = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (status_i.slot_free && status_i.merge_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.push_en  = in_valid_i &&
                         ((req == REQ_PUSH_FIRST) || (req == REQ_PUSH_SECOND));
      end
      ST_MERGE: begin
        cmd_o.merge_step = status_i.slot_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// File: hdl/ssm_datapath.sv
// ----------------------------------------------------------------------------
// ssm_datapath
// Datapath: two sequence buffers with fill counts, merge read pointers,
// head compare and the output result register.
// ----------------------------------------------------------------------------
module ssm_datapath
  import ssm_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ctrl_cmd_t                 cmd_i,
  output dp_status_t                status_o,
  input  logic [1:0]                req_type_i,
  input  logic signed [VALUE_W-1:0] value_in_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic signed [VALUE_W-1:0] merged_value_o,
  output logic                      from_second_o,
  output logic                      last_value_o,
  output logic                      merge_empty_o,
  output logic                      push_dropped_o
);

  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  logic signed [VALUE_W-1:0] buf_a_q [LIST_DEPTH];
  logic signed [VALUE_W-1:0] buf_b_q [LIST_DEPTH];
  logic [CNT_W-1:0]          cnt_a_q, cnt_a_d;
  logic [CNT_W-1:0]          cnt_b_q, cnt_b_d;
  logic [CNT_W-1:0]          rd_a_q, rd_a_d;
  logic [CNT_W-1:0]          rd_b_q, rd_b_d;
  logic                      ovf_q, ovf_d;

  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic                      out_second_q, out_last_q, out_empty_q, out_dropped_q;

  req_e                      req;
  logic                      wr_a, wr_b;
  logic                      a_left, b_left, both_empty, take_a, last;
  logic signed [VALUE_W-1:0] head_a, head_b;

  assign req = req_e'(req_type_i);

  // Push decode: a push to a full buffer only raises the drop flag
  assign wr_a = cmd_i.push_en && (req == REQ_PUSH_FIRST)  && (cnt_a_q < DEPTH_C);
  assign wr_b = cmd_i.push_en && (req == REQ_PUSH_SECOND) && (cnt_b_q < DEPTH_C);

  // Buffer storage, no reset
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      buf_a_q[cnt_a_q[IDX_W-1:0]] <= value_in_i;
    end
    if (wr_b) begin
      buf_b_q[cnt_b_q[IDX_W-1:0]] <= value_in_i;
    end
  end

  // Head selection; second sequence wins ties
  assign a_left     = rd_a_q < cnt_a_q;
  assign b_left     = rd_b_q < cnt_b_q;
  assign both_empty = !a_left && !b_left;
  assign head_a     = buf_a_q[rd_a_q[IDX_W-1:0]];
  assign head_b     = buf_b_q[rd_b_q[IDX_W-1:0]];
  assign take_a     = a_left && (!b_left || (head_a < head_b));
  assign last       = both_empty ||
                      (take_a  && ((rd_a_q + ONE_C) == cnt_a_q) && !b_left) ||
                      (!take_a && ((rd_b_q + ONE_C) == cnt_b_q) && !a_left);

  assign status_o.slot_free  = !out_valid_q || out_ready_i;
  assign status_o.merge_last = last;

  // Counters, read pointers and drop flag
  always_comb begin
    cnt_a_d = cnt_a_q;
    cnt_b_d = cnt_b_q;
    rd_a_d  = rd_a_q;
    rd_b_d  = rd_b_q;
    ovf_d   = ovf_q;
    if (cmd_i.push_en) begin
      if (wr_a) begin
        cnt_a_d = cnt_a_q + ONE_C;
      end else if (wr_b) begin
        cnt_b_d = cnt_b_q + ONE_C;
      end else if ((req == REQ_PUSH_FIRST) || (req == REQ_PUSH_SECOND)) begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.merge_step) begin
      if (last) begin
        cnt_a_d = '0;
        cnt_b_d = '0;
        rd_a_d  = '0;
        rd_b_d  = '0;
        ovf_d   = 1'b0;
      end else if (take_a) begin
        rd_a_d = rd_a_q + ONE_C;
      end else begin
        rd_b_d = rd_b_q + ONE_C;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      rd_a_q  <= '0;
      rd_b_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      rd_a_q  <= rd_a_d;
      rd_b_q  <= rd_b_d;
      ovf_q   <= ovf_d;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.merge_step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.merge_step) begin
      out_value_q   <= both_empty ? '0 : (take_a ? head_a : head_b);
      out_second_q  <= !take_a && !both_empty;
      out_last_q    <= last;
      out_empty_q   <= both_empty;
      out_dropped_q <= ovf_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign merged_value_o = out_value_q;
  assign from_second_o  = out_second_q;
  assign last_value_o   = out_last_q;
  assign merge_empty_o  = out_empty_q;
  assign push_dropped_o = out_dropped_q;

endmodule

// File: hdl/sorted_sequence_merger.sv
// ----------------------------------------------------------------------------
// sorted_sequence_merger
// Merges two ascending sequences of signed 32-bit values into one.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries requests: req_type 0 appends value_in to the first buffer,
//   1 to the second, 2 starts a merge; code 3 is taken and ignored.
//   out_ch carries merged results, one item per stored value, ascending,
//   with last_value on the final one. A tie emits the second sequence first.
//   A merge of two empty buffers gives a single item flagged merge_empty.
//   push_dropped reports a push that hit a full buffer since the last merge.
// Timing:
//   Pushes are taken one per cycle while idle. A taken merge request moves
//   the controller to its merge state; it then loads one result per cycle
//   into the output register while out_ch is ready, each chosen by the
//   single head compare. in_ch is held off until the final result is in
//   the output register; pushes may then resume while it waits to drain.
// Reset: both buffers empty, drop flag clear, no result pending.
// Stall: a stalled out_ch holds its result and the merge pauses in place.
// ----------------------------------------------------------------------------
module sorted_sequence_merger
  import ssm_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssm_in_if.sink     in_ch,
  ssm_out_if.source  out_ch
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Controller
  ssm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .req_type_i (in_ch.req_type),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath
  ssm_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .req_type_i     (in_ch.req_type),
    .value_in_i     (in_ch.value_in),
    .out_ready_i    (out_ch.ready),
    .out_valid_o    (out_ch.valid),
    .merged_value_o (out_ch.merged_value),
    .from_second_o  (out_ch.from_second),
    .last_value_o   (out_ch.last_value),
    .merge_empty_o  (out_ch.merge_empty),
    .push_dropped_o (out_ch.push_dropped)
  );

  assign in_ch.ready = cmd.in_ready;

  // A taken merge request blocks input on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready && (in_ch.req_type == REQ_MERGE) |=> !in_ch.ready)
    else $error("input accepted right after a merge request");

  // An empty merge is a single final item with a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.merge_empty |->
      out_ch.last_value && !out_ch.from_second && (out_ch.merged_value == 0))
    else $error("malformed empty merge result");

  // Input stays blocked while a non-final result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.last_value |-> !in_ch.ready)
    else $error("input accepted in the middle of a merge");

endmodule
